// File: rtl/mlma_pkg.sv
// Shared constants and types of the multi-lane moving average block.
`timescale 1ns / 1ps

package mlma_pkg;

  // Lane count is fixed by the per-lane ports of the top level.
  localparam int LANES = 6;

  localparam int WINDOW_DEF      = 50;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Control of the item sitting in the read-modify-write stage.
  typedef struct packed {
    logic valid;
    op_e  op;
    logic full;
  } rmw_ctl_t;

endpackage

// File: rtl/multi_lane_moving_average.sv
// Top level of the six-lane boxcar moving average filter.
`timescale 1ns / 1ps

// Six-lane boxcar moving average over the last WINDOW speed vectors.
// Opcode 0 pushes a vector of signed samples and drops the oldest one,
// opcode 1 flushes the window to zeros (as reset does), opcode 2 returns
// each lane's sum divided by WINDOW, truncated toward zero; opcode 3 is
// taken and ignored. One item is taken every cycle: the window row is read
// in the cycle of the transfer and written back from the read-modify-write
// stage, with the last write forwarded when a push lands on the slot just
// written. An average leaves through the sum, magnitude, reciprocal multiply
// and output registers after its tick transfer. Input stalls only while a
// finished average is blocked behind an output that is held by out_stall_i.

module multi_lane_moving_average #(
  parameter int WINDOW      = mlma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mlma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mlma_pkg::OP_W-1:0]     opcode_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_0_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_1_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_2_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_3_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_4_i,
  input  logic signed [SAMPLE_BITS-1:0] speed_5_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] avg_0_o,
  output logic signed [SAMPLE_BITS-1:0] avg_1_o,
  output logic signed [SAMPLE_BITS-1:0] avg_2_o,
  output logic signed [SAMPLE_BITS-1:0] avg_3_o,
  output logic signed [SAMPLE_BITS-1:0] avg_4_o,
  output logic signed [SAMPLE_BITS-1:0] avg_5_o
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

  logic                                        advance;
  logic                                        accept;
  logic [mlma_pkg::LANES-1:0][SAMPLE_BITS-1:0] speed;
  logic                                        tick;
  logic [mlma_pkg::LANES-1:0][SUM_W-1:0]       sums;
  logic                                        res_valid;
  logic [mlma_pkg::LANES-1:0][SAMPLE_BITS-1:0] res_avg;

  logic                                        out_valid_q, out_valid_d;
  logic [mlma_pkg::LANES-1:0][SAMPLE_BITS-1:0] avg_q;

  // Whole pipeline holds only when a result cannot move into the output.
  assign advance    = !(res_valid && out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  assign speed[0] = speed_0_i;
  assign speed[1] = speed_1_i;
  assign speed[2] = speed_2_i;
  assign speed[3] = speed_3_i;
  assign speed[4] = speed_4_i;
  assign speed[5] = speed_5_i;

  mlma_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .accept_i (accept),
    .op_i     (mlma_pkg::op_e'(opcode_i)),
    .speed_i  (speed),
    .tick_o   (tick),
    .sums_o   (sums)
  );

  mlma_divider #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (tick),
    .sums_i  (sums),
    .valid_o (res_valid),
    .avg_o   (res_avg)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      avg_q <= res_avg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_0_o     = avg_q[0];
  assign avg_1_o     = avg_q[1];
  assign avg_2_o     = avg_q[2];
  assign avg_3_o     = avg_q[3];
  assign avg_4_o     = avg_q[4];
  assign avg_5_o     = avg_q[5];

endmodule

// File: rtl/mlma_window.sv
// Window memory, write pointer, fill count and running lane sums.
`timescale 1ns / 1ps

module mlma_window #(
  parameter int WINDOW      = mlma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mlma_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          accept_i,
  input  mlma_pkg::op_e                                 op_i,
  input  logic [mlma_pkg::LANES-1:0][SAMPLE_BITS-1:0]   speed_i,
  output logic                                          tick_o,
  output logic [mlma_pkg::LANES-1:0][SUM_W-1:0]         sums_o
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int ROW_W  = mlma_pkg::LANES * SAMPLE_BITS;

  logic [ROW_W-1:0] mem [WINDOW];

  logic [SLOT_W-1:0] wpos_q, wpos_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  mlma_pkg::rmw_ctl_t ctl_q, ctl_d;
  logic [SLOT_W-1:0]  slot_q;
  logic [ROW_W-1:0]   samp_q;
  logic [ROW_W-1:0]   rdata_q;

  // Last row written, for a read of the same slot in the cycle of the write.
  logic               fwd_valid_q;
  logic [SLOT_W-1:0]  fwd_slot_q;
  logic [ROW_W-1:0]   fwd_data_q;

  logic [mlma_pkg::LANES-1:0][SUM_W-1:0] sums_q, sums_d;
  logic [ROW_W-1:0]   old_row;
  logic               is_push;
  logic               wr_en;
  logic               win_full;

  assign win_full = (fill_q == FILL_W'(WINDOW));
  assign is_push  = accept_i && (op_i == mlma_pkg::OP_PUSH);
  assign wr_en    = ctl_q.valid && (ctl_q.op == mlma_pkg::OP_PUSH);

  always_comb begin
    wpos_d = wpos_q;
    fill_d = fill_q;
    if (accept_i) begin
      case (op_i)
        mlma_pkg::OP_PUSH: begin
          wpos_d = (wpos_q == SLOT_W'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
          if (!win_full) begin
            fill_d = fill_q + 1'b1;
          end
        end
        mlma_pkg::OP_FLUSH: begin
          wpos_d = '0;
          fill_d = '0;
        end
        default: ;
      endcase
    end
    ctl_d.valid = accept_i;
    ctl_d.op    = op_i;
    ctl_d.full  = win_full;
  end

  always_comb begin
    logic signed [SUM_W-1:0] new_s;
    logic signed [SUM_W-1:0] old_s;
    old_row = '0;
    if (ctl_q.full) begin
      old_row = (fwd_valid_q && (fwd_slot_q == slot_q)) ? fwd_data_q : rdata_q;
    end
    sums_d = sums_q;
    if (ctl_q.valid) begin
      case (ctl_q.op)
        mlma_pkg::OP_PUSH: begin
          for (int k = 0; k < mlma_pkg::LANES; k++) begin
            new_s = SUM_W'($signed(samp_q[k*SAMPLE_BITS +: SAMPLE_BITS]));
            old_s = SUM_W'($signed(old_row[k*SAMPLE_BITS +: SAMPLE_BITS]));
            sums_d[k] = sums_q[k] + new_s - old_s;
          end
        end
        mlma_pkg::OP_FLUSH: sums_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      fill_q      <= '0;
      ctl_q       <= '0;
      fwd_valid_q <= 1'b0;
      sums_q      <= '0;
    end else if (en_i) begin
      wpos_q      <= wpos_d;
      fill_q      <= fill_d;
      ctl_q       <= ctl_d;
      fwd_valid_q <= wr_en;
      sums_q      <= sums_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slot_q     <= wpos_q;
      samp_q     <= speed_i;
      fwd_slot_q <= slot_q;
      fwd_data_q <= samp_q;
      if (is_push) begin
        rdata_q <= mem[wpos_q];
      end
      if (wr_en) begin
        mem[slot_q] <= samp_q;
      end
    end
  end

  // Tick sees the sums left by every earlier item.
  assign tick_o = ctl_q.valid && (ctl_q.op == mlma_pkg::OP_TICK);
  assign sums_o = sums_q;

endmodule

// File: rtl/mlma_divider.sv
// Per-lane division of the running sums by the window length.
`timescale 1ns / 1ps

module mlma_divider #(
  parameter int WINDOW      = mlma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mlma_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [mlma_pkg::LANES-1:0][SUM_W-1:0]         sums_i,
  output logic                                          valid_o,
  output logic [mlma_pkg::LANES-1:0][SAMPLE_BITS-1:0]   avg_o
);

  // Exact floor(n / WINDOW) for n < 2^SUM_W via multiply by a rounded-up
  // reciprocal and shift.
  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int M_W    = SUM_W + 2;
  localparam int PROD_W = SUM_W + M_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);

  logic                                        va_q, vb_q;
  logic [mlma_pkg::LANES-1:0][SUM_W-1:0]       mag_q, mag_d;
  logic [mlma_pkg::LANES-1:0]                  nega_q, negb_q;
  logic [mlma_pkg::LANES-1:0][SAMPLE_BITS-1:0] quo_q, quo_d;

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int k = 0; k < mlma_pkg::LANES; k++) begin
      mag_d[k] = sums_i[k][SUM_W-1] ? (~sums_i[k] + 1'b1) : sums_i[k];
      prod     = PROD_W'(mag_q[k]) * PROD_W'(RECIP_M);
      quo_d[k] = prod[SHIFT +: SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < mlma_pkg::LANES; k++) begin
        nega_q[k] <= sums_i[k][SUM_W-1];
      end
      mag_q  <= mag_d;
      negb_q <= nega_q;
      quo_q  <= quo_d;
    end
  end

  // Sign restored on the truncated magnitude: rounds toward zero.
  always_comb begin
    for (int k = 0; k < mlma_pkg::LANES; k++) begin
      avg_o[k] = negb_q[k] ? (~quo_q[k] + 1'b1) : quo_q[k];
    end
  end

  assign valid_o = vb_q;

endmodule

// File: verif/mlma_tb_pkg.sv
// Scoreboard and shared types for the multi-lane moving average testbench.
`timescale 1ns / 1ps

package mlma_tb_pkg;

  import mlma_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int SW  = SAMPLE_BITS_DEF;

  typedef logic [SW-1:0]             sample_t;
  typedef logic [LANES-1:0][SW-1:0]  lane_vec_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  class lane_average_board;
    int        hist [WIN][LANES];
    int        lane_sum [LANES];
    int        slot;
    int        fill;
    lane_vec_t expected_avgs [$];
    int        failures;
    int        n_push;
    int        n_flush;
    int        n_tick;
    int        n_ignored;
    int        n_full_ticks;
    int        n_checked;

    function new();
      clear_window();
    endfunction

    // Flush: memory is left alone, the fill count hides the old rows.
    function void clear_window();
      foreach (lane_sum[k]) lane_sum[k] = 0;
      slot = 0;
      fill = 0;
    endfunction

    function void apply_item(logic [OP_W-1:0] op, lane_vec_t speeds);
      lane_vec_t avgs;
      int        q;
      int        evicted;
      case (op)
        OP_PUSH: begin
          n_push++;
          for (int k = 0; k < LANES; k++) begin
            // below a full window the dropped row counts as zero
            evicted = (fill >= WIN) ? hist[slot][k] : 0;
            lane_sum[k] += $signed(speeds[k]) - evicted;
            hist[slot][k] = $signed(speeds[k]);
          end
          slot = (slot + 1) % WIN;
          if (fill < WIN) fill++;
        end
        OP_FLUSH: begin
          n_flush++;
          clear_window();
        end
        OP_TICK: begin
          n_tick++;
          if (fill >= WIN) n_full_ticks++;
          for (int k = 0; k < LANES; k++) begin
            q = lane_sum[k] / WIN;  // int division truncates toward zero
            avgs[k] = q[SW-1:0];
          end
          expected_avgs = {expected_avgs, avgs};
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_average(lane_vec_t got);
      lane_vec_t want;
      if (expected_avgs.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: average transfer with no tick pending, got %h", got);
        return;
      end
      want = expected_avgs.pop_front();
      n_checked++;
      for (int k = 0; k < LANES; k++) begin
        if (got[k] !== want[k]) begin
          failures++;
          if (failures <= 10)
            $display("ERROR: average %0d avg_%0d expected %0d got %0d",
                     n_checked, k, $signed(want[k]), $signed(got[k]));
        end
      end
    endfunction

    function int pending();
      return expected_avgs.size();
    endfunction
  endclass

endpackage

// File: verif/tb_multi_lane_moving_average.sv
// Self-checking testbench of the multi-lane moving average block.
`timescale 1ns / 1ps

module tb_multi_lane_moving_average;

  import mlma_pkg::*;
  import mlma_tb_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int ITEM_TARGET    = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_PAUSE      = 20;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef enum int {
    SEQ_PUSH_RUN,
    SEQ_SATURATE,
    SEQ_REFILL,
    SEQ_MIXED,
    SEQ_NOISE,
    SEQ_TICKS,
    SEQ_FLUSH_TICK
  } seq_kind_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic signed [SW-1:0] speed_0_i, speed_1_i, speed_2_i, speed_3_i, speed_4_i, speed_5_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [SW-1:0] avg_0_o, avg_1_o, avg_2_o, avg_3_o, avg_4_o, avg_5_o;

  lane_average_board board;
  int                items_sent;
  int                burst_left;
  int                idle_cycles = 0;
  bit                long_hold_req;

  multi_lane_moving_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .speed_0_i   (speed_0_i),
    .speed_1_i   (speed_1_i),
    .speed_2_i   (speed_2_i),
    .speed_3_i   (speed_3_i),
    .speed_4_i   (speed_4_i),
    .speed_5_i   (speed_5_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .avg_0_o     (avg_0_o),
    .avg_1_o     (avg_1_o),
    .avg_2_o     (avg_2_o),
    .avg_3_o     (avg_3_o),
    .avg_4_o     (avg_4_o),
    .avg_5_o     (avg_5_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Transfers are sampled at the edge, before any driver update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_average({avg_5_o, avg_4_o, avg_3_o, avg_2_o, avg_1_o, avg_0_o});
      if (in_valid_i && !in_stall_o)
        board.apply_item(opcode_i, {speed_5_i, speed_4_i, speed_3_i,
                                    speed_2_i, speed_1_i, speed_0_i});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", idle_cycles);
      $display("FAIL multi_lane_moving_average");
      $finish;
    end
  end

  // Output side: stall pattern in phases, plus one long hold on request.
  initial begin : out_side
    stall_mode_e mode;
    int          mode_left;
    int          phase;
    mode      = STALL_NONE;
    mode_left = 0;
    phase     = 0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(int'(STALL_NONE), int'(STALL_PERIODIC)));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= (phase % 3 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic lane_vec_t rand_vec();
    lane_vec_t v;
    sample_t   s;
    for (int k = 0; k < LANES; k++) begin
      case ($urandom_range(0, 7))
        0:       s = S_MAX;
        1:       s = S_MIN;
        2:       s = sample_t'($urandom_range(0, 64));
        3: begin
          s = sample_t'($urandom_range(1, 64));
          s = -s;
        end
        default: s = sample_t'($urandom);
      endcase
      v[k] = s;
    end
    return v;
  endfunction

  // Holds the item until it transfers; bursts end in a random gap.
  task automatic send_item(input logic [OP_W-1:0] op, input lane_vec_t sp);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    speed_0_i  <= sp[0];
    speed_1_i  <= sp[1];
    speed_2_i  <= sp[2];
    speed_3_i  <= sp[3];
    speed_4_i  <= sp[4];
    speed_5_i  <= sp[5];
    do @(posedge clk_i); while (in_stall_o);
    if (op != OP_RESERVED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 25);
    end
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  initial begin : stimulus
    lane_vec_t       v;
    logic [OP_W-1:0] op;
    seq_kind_e       kind;
    bit              hold_done;
    bit              drain_done;
    board        = new();
    items_sent   = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_PUSH;
    speed_0_i   <= '0;
    speed_1_i   <= '0;
    speed_2_i   <= '0;
    speed_3_i   <= '0;
    speed_4_i   <= '0;
    speed_5_i   <= '0;
    burst_left   = $urandom_range(0, 25);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty window, extremes, reserved opcode, flush, rounding
    send_item(OP_TICK, '0);
    send_item(OP_PUSH, {LANES{S_MAX}});
    send_item(OP_PUSH, {LANES{S_MIN}});
    send_item(OP_PUSH, {{3{16'h5555, 16'hAAAA}}});
    send_item(OP_PUSH, {16'h1000, S_MIN, S_MAX, 16'h0000, 16'h0001, 16'hFFFF});
    send_item(OP_TICK, '0);
    send_item(OP_RESERVED, rand_vec());
    send_item(OP_TICK, '0);
    send_item(OP_FLUSH, rand_vec());
    send_item(OP_TICK, '0);
    // -49 and +49 over the window must round toward zero, not down
    send_item(OP_PUSH, {{3{16'h0031, 16'hFFCF}}});
    send_item(OP_TICK, '0);
    send_item(OP_PUSH, {{3{16'h0001, 16'hFFFF}}});
    send_item(OP_TICK, '0);
    send_item(OP_FLUSH, '0);
    send_item(OP_FLUSH, '0);
    send_item(OP_TICK, '0);
    pause_until_drained();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 600) begin
        // output held off while ticks keep coming: the block must back up
        long_hold_req = 1'b1;
        repeat (40) send_item(OP_TICK, rand_vec());
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 1300) begin
        pause_until_drained();
        drain_done = 1'b1;
      end
      kind = seq_kind_e'($urandom_range(int'(SEQ_PUSH_RUN), int'(SEQ_FLUSH_TICK)));
      case (kind)
        SEQ_PUSH_RUN: begin
          repeat ($urandom_range(1, 2 * WIN + 20)) begin
            if ($urandom_range(0, 9) == 0) send_item(OP_TICK, rand_vec());
            send_item(OP_PUSH, rand_vec());
          end
          send_item(OP_TICK, rand_vec());
        end
        SEQ_SATURATE: begin
          for (int k = 0; k < LANES; k++) v[k] = $urandom_range(0, 1) ? S_MAX : S_MIN;
          repeat (WIN + $urandom_range(0, 10)) send_item(OP_PUSH, v);
          send_item(OP_TICK, rand_vec());
        end
        SEQ_REFILL: begin
          send_item(OP_FLUSH, rand_vec());
          repeat ($urandom_range(0, WIN - 1)) send_item(OP_PUSH, rand_vec());
          send_item(OP_TICK, rand_vec());
          repeat ($urandom_range(1, WIN)) send_item(OP_PUSH, rand_vec());
          send_item(OP_TICK, rand_vec());
        end
        SEQ_MIXED: begin
          repeat ($urandom_range(1, 10)) begin
            op = OP_W'($urandom_range(int'(OP_PUSH), int'(OP_TICK)));
            send_item(op, rand_vec());
          end
        end
        SEQ_NOISE: begin
          repeat ($urandom_range(1, 6)) begin
            op = OP_W'($urandom);
            send_item(op, rand_vec());
          end
        end
        SEQ_TICKS: repeat ($urandom_range(1, 6)) send_item(OP_TICK, rand_vec());
        default: begin
          send_item(OP_FLUSH, rand_vec());
          send_item(OP_TICK, rand_vec());
        end
      endcase
    end

    pause_until_drained();
    repeat (END_PAUSE) @(posedge clk_i);

    $display("Run: %0d pushes, %0d flushes, %0d ticks, %0d reserved opcodes dropped",
             board.n_push, board.n_flush, board.n_tick, board.n_ignored);
    $display("Averages checked: %0d (%0d over a full window), errors: %0d",
             board.n_checked, board.n_full_ticks, board.failures);
    if (board.pending() != 0)
      $display("ERROR: %0d averages never came out", board.pending());
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS multi_lane_moving_average");
    end else begin
      $display("FAIL multi_lane_moving_average");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mlma_pkg.sv
rtl/mlma_window.sv
rtl/mlma_divider.sv
rtl/multi_lane_moving_average.sv
verif/mlma_tb_pkg.sv
verif/tb_multi_lane_moving_average.sv
